@@ rtl/rkpf_pkg.sv @@
// ----------------------------------------------------------------------------
// rkpf_pkg: shared definitions for the range keeping PI follower
// Register indexes, reset values, wrap constant and constant dividers.
// ----------------------------------------------------------------------------
package rkpf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_RANGE    = 3'd0;
    localparam logic [2:0] REG_CRUISE_SPEED    = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN       = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_GAIN   = 3'd3;
    localparam logic [2:0] REG_NEG_ERR_MULT    = 3'd4;
    localparam logic [2:0] REG_INTEGRAL_LIMIT  = 3'd5;
    localparam logic [2:0] REG_SPEED_BAND_PCT  = 3'd6;
    localparam logic [2:0] REG_TURN_GAIN       = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_TARGET_RANGE   = 16'd0;
    localparam logic [11:0] RST_CRUISE_SPEED   = 12'd0;
    localparam logic [9:0]  RST_PROP_GAIN      = 10'd100;
    localparam logic [7:0]  RST_INTEGRAL_GAIN  = 8'd4;
    localparam logic [2:0]  RST_NEG_ERR_MULT   = 3'd2;
    localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd10000;
    localparam logic [6:0]  RST_SPEED_BAND_PCT = 7'd25;
    localparam logic [7:0]  RST_TURN_GAIN      = 8'd60;

    localparam logic [6:0]  BAND_MAX_PCT       = 7'd100;

    // Half a turn in milliradians; bearings wrap by whole turns of twice this.
    localparam int HALF_TURN_MRAD = 3142;

    // Exact division by 1000 for operands below 2**26: multiply by the
    // rounded-up reciprocal and shift.
    localparam int          DIV1K_SHIFT = 36;
    localparam logic [26:0] DIV1K_MULT  =
        27'(((64'd1 << DIV1K_SHIFT) + 64'd999) / 64'd1000);

    // Exact division by 100 for operands below 2**20.
    localparam int          DIV100_SHIFT = 27;
    localparam logic [20:0] DIV100_MULT  =
        21'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

    function automatic logic [16:0] div1000(input logic [25:0] x);
        logic [52:0] prod;
        prod = {27'd0, x} * {26'd0, DIV1K_MULT};
        return prod[52:36];
    endfunction

    // Every quotient the block forms this way stays below 2**13.
    function automatic logic [12:0] div100(input logic [19:0] x);
        logic [40:0] prod;
        prod = {21'd0, x} * {20'd0, DIV100_MULT};
        return prod[39:27];
    endfunction

endpackage

@@ rtl/range_keeping_pi_follower_top.sv @@
// ----------------------------------------------------------------------------
// range_keeping_pi_follower_top: PI range follower with clamped integrator
// Turns neighbour sightings into forward speed and turn rate commands.
// ----------------------------------------------------------------------------
// Usage:
// Sightings enter on the s_ channel, one transaction per sighting; each
// produces exactly one command transaction on the m_ channel, in order.
// Gains, limits and the target range sit in eight registers written over
// the cfg_ channel (cfg_ready is always high); write them only while the
// block is idle.
// A sighting passes through stage 1, stage 2, stage 3 and the output register
// before it shows up on m_valid. Throughput is one sighting per cycle while
// the receiver keeps m_ready high; the figure is set by the integrator update,
// which completes in the accept cycle so the next sighting sees the new value.
// A sighting without a neighbour gives a zero command and leaves the
// integrator alone.
// Reset clears the integrator, empties the pipeline and loads the default
// register values. When the receiver stalls, the four pipeline stages fill
// up and s_ready drops once all of them hold a transaction.
// ----------------------------------------------------------------------------
module range_keeping_pi_follower_top (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_neighbour_present,
    input  logic [15:0]        s_neighbour_range,
    input  logic signed [13:0] s_neighbour_bearing,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_drive_active,
    output logic [12:0]        m_forward_speed,
    output logic signed [13:0] m_turn_rate
);

    localparam logic signed [14:0] HALF_TURN = 15'(rkpf_pkg::HALF_TURN_MRAD);
    localparam logic signed [14:0] FULL_TURN = 15'(2 * rkpf_pkg::HALF_TURN_MRAD);

    // Configuration registers.
    logic [15:0] target_range_reg;
    logic [11:0] cruise_speed_reg;
    logic [9:0]  prop_gain_reg;
    logic [7:0]  integral_gain_reg;
    logic [2:0]  neg_err_mult_reg;
    logic [14:0] integral_limit_reg;
    logic [6:0]  speed_band_reg;
    logic [7:0]  turn_gain_reg;

    logic signed [15:0] integ_reg;
    logic signed [15:0] integ_next;

    // Pipeline control.
    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, out_valid_reg;
    logic st1_free, st2_free, st3_free, out_free;
    logic in_accept;

    // Stage 1: error, integrator and wrapped bearing as sign and magnitude.
    logic        st1_present_reg;
    logic        st1_e_neg_reg;
    logic [15:0] st1_e_mag_reg;
    logic        st1_acc_neg_reg;
    logic [14:0] st1_acc_mag_reg;
    logic        st1_q_neg_reg;
    logic [11:0] st1_q_mag_reg;

    // Stage 2: products.
    logic        st2_present_reg;
    logic        st2_e_neg_reg;
    logic        st2_acc_neg_reg;
    logic        st2_q_neg_reg;
    logic [25:0] st2_p_prod_reg;
    logic [22:0] st2_i_prod_reg;
    logic [19:0] st2_lo_prod_reg;
    logic [19:0] st2_hi_prod_reg;
    logic [19:0] st2_t_prod_reg;

    // Stage 3: quotients.
    logic        st3_present_reg;
    logic        st3_e_neg_reg;
    logic        st3_acc_neg_reg;
    logic        st3_q_neg_reg;
    logic [16:0] st3_p_quo_reg;
    logic [13:0] st3_i_quo_reg;
    logic [12:0] st3_lo_reg;
    logic [12:0] st3_hi_reg;
    logic [12:0] st3_t_quo_reg;

    // Output register.
    logic               out_active_reg;
    logic [12:0]        out_speed_reg;
    logic signed [13:0] out_turn_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_range_reg   <= rkpf_pkg::RST_TARGET_RANGE;
            cruise_speed_reg   <= rkpf_pkg::RST_CRUISE_SPEED;
            prop_gain_reg      <= rkpf_pkg::RST_PROP_GAIN;
            integral_gain_reg  <= rkpf_pkg::RST_INTEGRAL_GAIN;
            neg_err_mult_reg   <= rkpf_pkg::RST_NEG_ERR_MULT;
            integral_limit_reg <= rkpf_pkg::RST_INTEGRAL_LIMIT;
            speed_band_reg     <= rkpf_pkg::RST_SPEED_BAND_PCT;
            turn_gain_reg      <= rkpf_pkg::RST_TURN_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rkpf_pkg::REG_TARGET_RANGE:   target_range_reg   <= cfg_data;
                rkpf_pkg::REG_CRUISE_SPEED:   cruise_speed_reg   <= cfg_data[11:0];
                rkpf_pkg::REG_PROP_GAIN:      prop_gain_reg      <= cfg_data[9:0];
                rkpf_pkg::REG_INTEGRAL_GAIN:  integral_gain_reg  <= cfg_data[7:0];
                rkpf_pkg::REG_NEG_ERR_MULT:   neg_err_mult_reg   <= cfg_data[2:0];
                rkpf_pkg::REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[14:0];
                rkpf_pkg::REG_SPEED_BAND_PCT: speed_band_reg     <= cfg_data[6:0];
                rkpf_pkg::REG_TURN_GAIN:      turn_gain_reg      <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || m_ready;
    assign st3_free  = !st3_valid_reg || out_free;
    assign st2_free  = !st2_valid_reg || st3_free;
    assign st1_free  = !st1_valid_reg || st2_free;
    assign s_ready   = st1_free;
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_free) begin
                st1_valid_reg <= s_valid;
            end
            if (st2_free) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (st3_free) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= st3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: range error and integrator update, done in the accept cycle.
    // ------------------------------------------------------------------
    logic signed [16:0] err_next;
    logic signed [20:0] neg_term_next;
    logic signed [21:0] acc_sum_next;
    logic signed [21:0] lim_pos;
    logic signed [21:0] acc_clamp_next;
    logic signed [16:0] e_abs_next;
    logic signed [15:0] acc_abs_next;
    logic signed [14:0] nbear_next;
    logic signed [14:0] q_next;
    logic signed [14:0] q_abs_next;

    always_comb begin
        err_next      = $signed({1'b0, s_neighbour_range}) - $signed({1'b0, target_range_reg});
        neg_term_next = $signed({1'b0, neg_err_mult_reg}) * err_next;

        // Positive errors go in as they are, others through the multiplier.
        if (!err_next[16] && (err_next != 17'sd0)) begin
            acc_sum_next = 22'(integ_reg) + 22'(err_next);
        end else begin
            acc_sum_next = 22'(integ_reg) + 22'(neg_term_next);
        end

        lim_pos = $signed({7'd0, integral_limit_reg});
        if (acc_sum_next > lim_pos) begin
            acc_clamp_next = lim_pos;
        end else if (acc_sum_next < -lim_pos) begin
            acc_clamp_next = -lim_pos;
        end else begin
            acc_clamp_next = acc_sum_next;
        end
        integ_next = acc_clamp_next[15:0];

        e_abs_next   = err_next[16] ? -err_next : err_next;
        acc_abs_next = integ_next[15] ? -integ_next : integ_next;

        // Negated bearing, wrapped once by a full turn into a half turn.
        nbear_next = 15'sd0 - 15'(s_neighbour_bearing);
        if (nbear_next > HALF_TURN) begin
            q_next = nbear_next - FULL_TURN;
        end else if (nbear_next < -HALF_TURN) begin
            q_next = nbear_next + FULL_TURN;
        end else begin
            q_next = nbear_next;
        end
        q_abs_next = q_next[14] ? -q_next : q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= 16'sd0;
        end else if (in_accept && s_neighbour_present) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            st1_present_reg <= s_neighbour_present;
            st1_e_neg_reg   <= err_next[16];
            st1_e_mag_reg   <= e_abs_next[15:0];
            st1_acc_neg_reg <= integ_next[15];
            st1_acc_mag_reg <= acc_abs_next[14:0];
            st1_q_neg_reg   <= q_next[14];
            st1_q_mag_reg   <= q_abs_next[11:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gain products and speed band edges.
    // ------------------------------------------------------------------
    logic [6:0] band_pct;

    assign band_pct = (speed_band_reg > rkpf_pkg::BAND_MAX_PCT) ?
                      rkpf_pkg::BAND_MAX_PCT : speed_band_reg;

    always_ff @(posedge aclk) begin
        if (st2_free && st1_valid_reg) begin
            st2_present_reg <= st1_present_reg;
            st2_e_neg_reg   <= st1_e_neg_reg;
            st2_acc_neg_reg <= st1_acc_neg_reg;
            st2_q_neg_reg   <= st1_q_neg_reg;
            st2_p_prod_reg  <= {16'd0, prop_gain_reg} * {10'd0, st1_e_mag_reg};
            st2_i_prod_reg  <= {15'd0, integral_gain_reg} * {8'd0, st1_acc_mag_reg};
            st2_lo_prod_reg <= {8'd0, cruise_speed_reg} *
                               {12'd0, 8'd100 - {1'b0, band_pct}};
            st2_hi_prod_reg <= {8'd0, cruise_speed_reg} *
                               {12'd0, 8'd100 + {1'b0, band_pct}};
            st2_t_prod_reg  <= {8'd0, st1_q_mag_reg} * {12'd0, turn_gain_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: constant divisions on magnitudes, so they truncate toward zero.
    // ------------------------------------------------------------------
    logic [16:0] i_quo_full;

    assign i_quo_full = rkpf_pkg::div1000({3'd0, st2_i_prod_reg});

    always_ff @(posedge aclk) begin
        if (st3_free && st2_valid_reg) begin
            st3_present_reg <= st2_present_reg;
            st3_e_neg_reg   <= st2_e_neg_reg;
            st3_acc_neg_reg <= st2_acc_neg_reg;
            st3_q_neg_reg   <= st2_q_neg_reg;
            st3_p_quo_reg   <= rkpf_pkg::div1000(st2_p_prod_reg);
            st3_i_quo_reg   <= i_quo_full[13:0];
            st3_lo_reg      <= rkpf_pkg::div100(st2_lo_prod_reg);
            st3_hi_reg      <= rkpf_pkg::div100(st2_hi_prod_reg);
            st3_t_quo_reg   <= rkpf_pkg::div100(st2_t_prod_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sum, band clamp and sign of the turn rate.
    // ------------------------------------------------------------------
    logic signed [19:0] p_term;
    logic signed [19:0] i_term;
    logic signed [19:0] speed_sum;
    logic signed [19:0] lo_edge;
    logic signed [19:0] hi_edge;
    logic signed [19:0] speed_clamp;
    logic [12:0]        speed_next;
    logic signed [13:0] turn_next;

    always_comb begin
        p_term = st3_e_neg_reg ? -$signed({3'd0, st3_p_quo_reg})
                               :  $signed({3'd0, st3_p_quo_reg});
        i_term = st3_acc_neg_reg ? -$signed({6'd0, st3_i_quo_reg})
                                 :  $signed({6'd0, st3_i_quo_reg});
        speed_sum = $signed({8'd0, cruise_speed_reg}) + p_term + i_term;
        lo_edge   = $signed({7'd0, st3_lo_reg});
        hi_edge   = $signed({7'd0, st3_hi_reg});

        // The lower edge is never negative, so this also floors at zero.
        if (speed_sum < lo_edge) begin
            speed_clamp = lo_edge;
        end else if (speed_sum > hi_edge) begin
            speed_clamp = hi_edge;
        end else begin
            speed_clamp = speed_sum;
        end

        if (st3_present_reg) begin
            speed_next = speed_clamp[12:0];
            // The turn rate opposes the sign of the wrapped negated bearing.
            turn_next  = st3_q_neg_reg ? $signed({1'b0, st3_t_quo_reg})
                                       : -$signed({1'b0, st3_t_quo_reg});
        end else begin
            speed_next = 13'd0;
            turn_next  = 14'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && st3_valid_reg) begin
            out_active_reg <= st3_present_reg;
            out_speed_reg  <= speed_next;
            out_turn_reg   <= turn_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_drive_active  = out_active_reg;
    assign m_forward_speed = out_speed_reg;
    assign m_turn_rate     = out_turn_reg;

`ifndef SYNTHESIS
    // The integrator never leaves the limit that was in force at its update.
    a_integ_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_neighbour_present) |=>
            ((integ_reg <= $signed({1'b0, $past(integral_limit_reg)})) &&
             (integ_reg >= -$signed({1'b0, $past(integral_limit_reg)}))))
        else $error("integrator outside its limit");

    // Only an accepted sighting with a neighbour moves the integrator.
    a_integ_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_accept && s_neighbour_present) |=> $stable(integ_reg))
        else $error("integrator changed without a sighting");

    // An inactive command carries no motion.
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_active) |->
            ((m_forward_speed == 13'd0) && (m_turn_rate == 14'sd0)))
        else $error("inactive command with nonzero motion");

    // Input backpressure only appears with every stage occupied.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (st1_valid_reg && st2_valid_reg && st3_valid_reg &&
                      out_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
